[src/vbp_pkg.sv]
// Shared widths, camera constants, register indexes and helpers for the vertex projection block.
package vbp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUND_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FACING   = 3'd5;

	// gain divider geometry
	localparam int GAIN_W  = 28;
	localparam int NUM_W   = 61;
	localparam int DEN_W   = 45;
	localparam int DIV_LAT = GAIN_W + 1;

	// Q0.16 camera trig
	localparam logic signed [16:0] COS_YAW   = 17'sd53338;
	localparam logic signed [16:0] SIN_YAW   = 17'sd38079;
	localparam logic signed [16:0] COS_PITCH = 17'sd62609;
	localparam logic signed [16:0] SIN_PITCH = 17'sd19367;

	localparam logic signed [28:0] ORBIT          = 29'sd14336000;
	localparam logic signed [46:0] BASE_DENOM     = 47'sd1509949440000;
	localparam logic [28:0]        GAIN_NUM_SCALE = 29'd368640000;

	// reciprocals of 25 for the three widths that get divided
	localparam logic [46:0] RECIP25_WIDE = 47'd90071992547410;
	localparam logic [31:0] RECIP25_MID  = 32'd2748779070;
	localparam logic [23:0] RECIP25_NAR  = 24'd10737419;

	typedef struct packed {
		logic [28:0] px;
		logic [28:0] zz;
		logic [15:0] wx;
		logic [15:0] wy;
		logic [15:0] wz;
		logic [15:0] vd;
		logic        behind;
	} side_t;

	function automatic logic [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767) begin
			return 16'h7fff;
		end else if (v < -40'sd32768) begin
			return 16'h8000;
		end else begin
			return v[15:0];
		end
	endfunction

	function automatic logic [18:0] sat19(input logic signed [39:0] v);
		if (v > 40'sd262143) begin
			return 19'h3ffff;
		end else if (v < -40'sd262144) begin
			return 19'h40000;
		end else begin
			return v[18:0];
		end
	endfunction

endpackage

[src/vbp_gain_div.sv]
// Pipelined restoring divider for the perspective gain, one quotient bit per stage.
module vbp_gain_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [vbp_pkg::NUM_W-1:0]  num,
	input  logic [vbp_pkg::DEN_W-1:0]  den,
	output logic                       out_vld,
	output logic [vbp_pkg::GAIN_W-1:0] gain
);
	localparam int LAT   = vbp_pkg::DIV_LAT;
	localparam int GW    = vbp_pkg::GAIN_W;
	localparam int NW    = vbp_pkg::NUM_W;
	localparam int CMP_W = vbp_pkg::DEN_W + GW;

	logic [LAT-1:0] vld_s;
	logic           ovf_s [LAT];
	logic [NW-1:0]  rem_s [LAT];
	logic [vbp_pkg::DEN_W-1:0] den_s [LAT];
	logic [GW-1:0]  quo_s [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], in_vld};
		end
	end

	// quotient that does not fit the gain width saturates
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= {{(CMP_W-NW){1'b0}}, num} >= {den, {GW{1'b0}}};
	end

	for (genvar i = 1; i < LAT; i++) begin : g_step
		localparam int K = LAT - 1 - i;
		logic [CMP_W:0] diff;
		logic [GW-1:0]  qbit;

		assign diff = {1'b0, {(CMP_W-NW){1'b0}}, rem_s[i-1]}
			- ({{(GW+1){1'b0}}, den_s[i-1]} << K);
		assign qbit = {{(GW-1){1'b0}}, 1'b1} << K;

		always_ff @(posedge clk) begin
			den_s[i] <= den_s[i-1];
			ovf_s[i] <= ovf_s[i-1];
			if (!diff[CMP_W]) begin
				rem_s[i] <= diff[NW-1:0];
				quo_s[i] <= quo_s[i-1] | qbit;
			end else begin
				rem_s[i] <= rem_s[i-1];
				quo_s[i] <= quo_s[i-1];
			end
		end
	end

	assign out_vld = vld_s[LAT-1];
	assign gain    = ovf_s[LAT-1] ? {GW{1'b1}} : quo_s[LAT-1];

endmodule

[src/vertex_blend_project.sv]
// Top level of the vertex blend and perspective projection pipeline.
//
// Usage: drive one vertex (two animation-frame positions) on the first_* and
// second_* ports and pulse start; the vertex is taken at any clock edge where
// start is high and busy is low. busy is high only in the first cycle after
// reset is released, so a new vertex can be taken every cycle.
// Each vertex yields exactly one item on the world_*, screen_*, view_depth and
// behind ports, shown for one cycle with done high. The vertex passes 42
// register stages, the first loaded at the edge that took the vertex: 7
// transform stages, the 29 stages of the gain divider (an overflow check, then
// one quotient bit per stage) and 6 stages of scaling and output registers.
// Items leave in the order they came in.
// The receiver cannot stall: it must take the item in the cycle done is high.
// Configuration: write register cfg_index with cfg_data through cfg_valid and
// cfg_ready (always ready); indexes past facing are dropped. Write only while
// no vertex is in flight. Reset loads centre 0, ground 0, zoom and stretch 1.0,
// blend 0 and positive facing, and empties the pipeline.
module vertex_blend_project (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [15:0]                first_x,
	input  logic signed [15:0]                first_y,
	input  logic signed [15:0]                first_z,
	input  logic signed [15:0]                second_x,
	input  logic signed [15:0]                second_y,
	input  logic signed [15:0]                second_z,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              done,
	output logic signed [15:0]                world_x,
	output logic signed [15:0]                world_y,
	output logic signed [15:0]                world_z,
	output logic signed [18:0]                screen_x,
	output logic signed [18:0]                screen_y,
	output logic signed [15:0]                view_depth,
	output logic                              behind
);
	localparam int LAT = vbp_pkg::DIV_LAT;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic signed [18:0] centre_x_q, ground_y_q;
	logic [15:0]        zoom_q, stretch_q;
	logic [11:0]        blend_fraction_q;
	logic               facing_q;
	logic [vbp_pkg::NUM_W-1:0] num_q;
	logic [44:0]        nscale_c;
	logic               busy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q       <= '0;
			ground_y_q       <= '0;
			zoom_q           <= 16'd4096;
			stretch_q        <= 16'd4096;
			blend_fraction_q <= '0;
			facing_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vbp_pkg::REG_CENTRE_X: centre_x_q       <= cfg_data[18:0];
				vbp_pkg::REG_GROUND_Y: ground_y_q       <= cfg_data[18:0];
				vbp_pkg::REG_ZOOM:     zoom_q           <= cfg_data[15:0];
				vbp_pkg::REG_STRETCH:  stretch_q        <= cfg_data[15:0];
				vbp_pkg::REG_BLEND:    blend_fraction_q <= cfg_data[11:0];
				vbp_pkg::REG_FACING:   facing_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Busy is set by reset and cleared by the next clock edge, so the config settles first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end
	assign busy = busy_q;

	// Gain numerator depends only on zoom; track it every cycle.
	assign nscale_c = zoom_q * vbp_pkg::GAIN_NUM_SCALE;
	always_ff @(posedge clk) begin
		num_q <= {nscale_c, 16'b0};
	end

	// ---------------------------------------------------------------
	// Helpers
	// ---------------------------------------------------------------
	function automatic logic signed [28:0] blend(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [12:0] f);
		logic signed [29:0] acc;
		acc = $signed({a, 12'b0}) + (b - a) * f;
		return acc[28:0];
	endfunction

	// round hundredths*4096 back to hundredths, saturate
	function automatic logic [15:0] world_round(input logic signed [28:0] v);
		logic signed [29:0] sum;
		logic signed [17:0] q;
		logic signed [39:0] w;
		sum = v + 30'sd2048;
		q   = sum[29:12];
		w   = q;
		return vbp_pkg::sat16(w);
	endfunction

	// ---------------------------------------------------------------
	// Valid chain
	// ---------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s37, vld_s38, vld_s39, vld_s40, vld_s41;
	logic div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s37 <= 1'b0;
			vld_s38 <= 1'b0;
			vld_s39 <= 1'b0;
			vld_s40 <= 1'b0;
			vld_s41 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s1  <= start && !busy_q;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s37 <= div_vld;
			vld_s38 <= vld_s37;
			vld_s39 <= vld_s38;
			vld_s40 <= vld_s39;
			vld_s41 <= vld_s40;
			done    <= vld_s41;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: blend the two frames (exact, 12 fraction bits)
	// ---------------------------------------------------------------
	logic signed [12:0] frac_s;
	logic signed [28:0] mx_s1, my_s1, mz_s1;

	assign frac_s = {1'b0, blend_fraction_q};

	always_ff @(posedge clk) begin
		mx_s1 <= blend(first_x, second_x, frac_s);
		my_s1 <= blend(first_y, second_y, frac_s);
		mz_s1 <= blend(first_z, second_z, frac_s);
	end

	// ---------------------------------------------------------------
	// Stage 2: quarter turn by facing, yaw products, world outputs
	// ---------------------------------------------------------------
	logic signed [28:0] wx_c, wy_c;
	logic signed [45:0] ycy_s2, xsy_s2, ysy_s2, xcy_s2;
	logic signed [28:0] pz_s2;
	logic [15:0]        wxo_s2, wyo_s2, wzo_s2;

	always_comb begin
		if (facing_q) begin
			wx_c = my_s1;
			wy_c = -mx_s1;
		end else begin
			wx_c = -my_s1;
			wy_c = mx_s1;
		end
	end

	always_ff @(posedge clk) begin
		ycy_s2 <= wy_c * vbp_pkg::COS_YAW;
		xsy_s2 <= wx_c * vbp_pkg::SIN_YAW;
		ysy_s2 <= wy_c * vbp_pkg::SIN_YAW;
		xcy_s2 <= wx_c * vbp_pkg::COS_YAW;
		pz_s2  <= mz_s1 - vbp_pkg::ORBIT;
		wxo_s2 <= world_round(wx_c);
		wyo_s2 <= world_round(wy_c);
		wzo_s2 <= world_round(mz_s1);
	end

	// ---------------------------------------------------------------
	// Stage 3: round yaw sums
	// ---------------------------------------------------------------
	logic signed [46:0] pxa_c, pya_c;
	logic signed [28:0] px_s3, py_s3, pz_s3;
	logic [15:0]        wxo_s3, wyo_s3, wzo_s3;

	assign pxa_c = ycy_s2 - xsy_s2 + 47'sd32768;
	assign pya_c = ysy_s2 + xcy_s2 + 47'sd32768;

	always_ff @(posedge clk) begin
		px_s3  <= pxa_c[44:16];
		py_s3  <= pya_c[44:16];
		pz_s3  <= pz_s2;
		wxo_s3 <= wxo_s2;
		wyo_s3 <= wyo_s2;
		wzo_s3 <= wzo_s2;
	end

	// ---------------------------------------------------------------
	// Stage 4: pitch products
	// ---------------------------------------------------------------
	logic signed [45:0] zcp_s4, ysp_s4, zsp_s4, ycp_s4;
	logic signed [28:0] px_s4;
	logic [15:0]        wxo_s4, wyo_s4, wzo_s4;

	always_ff @(posedge clk) begin
		zcp_s4 <= pz_s3 * vbp_pkg::COS_PITCH;
		ysp_s4 <= py_s3 * vbp_pkg::SIN_PITCH;
		zsp_s4 <= pz_s3 * vbp_pkg::SIN_PITCH;
		ycp_s4 <= py_s3 * vbp_pkg::COS_PITCH;
		px_s4  <= px_s3;
		wxo_s4 <= wxo_s3;
		wyo_s4 <= wyo_s3;
		wzo_s4 <= wzo_s3;
	end

	// ---------------------------------------------------------------
	// Stage 5: round pitch sums into height and depth
	// ---------------------------------------------------------------
	logic signed [46:0] zza_c, dda_c;
	logic signed [28:0] zz_s5, dd_s5, px_s5;
	logic [15:0]        wxo_s5, wyo_s5, wzo_s5;

	assign zza_c = zcp_s4 - ysp_s4 + 47'sd32768;
	assign dda_c = zsp_s4 + ycp_s4 + 47'sd32768;

	always_ff @(posedge clk) begin
		zz_s5  <= zza_c[44:16];
		dd_s5  <= dda_c[44:16];
		px_s5  <= px_s4;
		wxo_s5 <= wxo_s4;
		wyo_s5 <= wyo_s4;
		wzo_s5 <= wzo_s4;
	end

	// ---------------------------------------------------------------
	// Stage 6: depth times zoom; depth/64 magnitude for view_depth
	// ---------------------------------------------------------------
	logic signed [16:0] zoom_s;
	logic signed [29:0] vda_c;
	logic signed [23:0] y3_c;
	logic signed [24:0] n3_c;
	logic signed [45:0] dz_s6;
	logic [23:0]        u3_s6;
	logic               neg3_s6;
	logic signed [28:0] zz_s6, px_s6;
	logic [15:0]        wxo_s6, wyo_s6, wzo_s6;

	assign zoom_s = {1'b0, zoom_q};
	assign vda_c  = dd_s5 + 30'sd800;
	assign y3_c   = vda_c[29:6];
	assign n3_c   = 25'sd24 - y3_c;

	always_ff @(posedge clk) begin
		dz_s6   <= dd_s5 * zoom_s;
		neg3_s6 <= y3_c[23];
		u3_s6   <= y3_c[23] ? n3_c[23:0] : y3_c[23:0];
		zz_s6   <= zz_s5;
		px_s6   <= px_s5;
		wxo_s6  <= wxo_s5;
		wyo_s6  <= wyo_s5;
		wzo_s6  <= wzo_s5;
	end

	// ---------------------------------------------------------------
	// Stage 7: perspective denominator, behind test, divider operands
	// ---------------------------------------------------------------
	logic signed [46:0] den_c;
	logic               behind_c;
	logic [vbp_pkg::DEN_W-1:0] den_s7;
	logic [vbp_pkg::NUM_W-1:0] nprime_s7;
	logic               behind_s7, neg3_s7;
	logic [47:0]        vdp_s7;
	logic signed [28:0] zz_s7, px_s7;
	logic [15:0]        wxo_s7, wyo_s7, wzo_s7;

	assign den_c    = vbp_pkg::BASE_DENOM + dz_s6;
	assign behind_c = den_c <= 47'sd0;

	always_ff @(posedge clk) begin
		den_s7    <= behind_c ? 45'd1 : den_c[44:0];
		nprime_s7 <= num_q + {17'b0, den_c[44:1]};
		behind_s7 <= behind_c;
		vdp_s7    <= u3_s6 * vbp_pkg::RECIP25_NAR;
		neg3_s7   <= neg3_s6;
		zz_s7     <= zz_s6;
		px_s7     <= px_s6;
		wxo_s7    <= wxo_s6;
		wyo_s7    <= wyo_s6;
		wzo_s7    <= wzo_s6;
	end

	// finish view depth and pack what rides alongside the divider
	logic signed [20:0] q3_c;
	logic signed [20:0] vd_c;
	logic signed [39:0] vdw_c;
	vbp_pkg::side_t     side_in;

	assign q3_c  = {1'b0, vdp_s7[47:28]};
	assign vd_c  = neg3_s7 ? -q3_c : q3_c;
	assign vdw_c = vd_c;

	always_comb begin
		side_in.px     = px_s7;
		side_in.zz     = zz_s7;
		side_in.wx     = wxo_s7;
		side_in.wy     = wyo_s7;
		side_in.wz     = wzo_s7;
		side_in.vd     = vbp_pkg::sat16(vdw_c);
		side_in.behind = behind_s7;
	end

	// ---------------------------------------------------------------
	// Gain divider and matching delay line
	// ---------------------------------------------------------------
	logic [vbp_pkg::GAIN_W-1:0] gain;
	vbp_pkg::side_t side_d [LAT];

	vbp_gain_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s7),
		.num     (nprime_s7),
		.den     (den_s7),
		.out_vld (div_vld),
		.gain    (gain)
	);

	always_ff @(posedge clk) begin
		side_d[0] <= side_in;
		for (int i = 1; i < LAT; i++) begin
			side_d[i] <= side_d[i-1];
		end
	end

	// ---------------------------------------------------------------
	// Stage 37: gain products
	// ---------------------------------------------------------------
	logic signed [28:0] gain_s;
	logic signed [28:0] pxd_c, zzd_c;
	logic signed [57:0] pg_s37, zg_s37;
	vbp_pkg::side_t     side_s37;

	assign gain_s = {1'b0, gain};
	assign pxd_c  = side_d[LAT-1].px;
	assign zzd_c  = side_d[LAT-1].zz;

	always_ff @(posedge clk) begin
		pg_s37   <= pxd_c * gain_s;
		zg_s37   <= zzd_c * gain_s;
		side_s37 <= side_d[LAT-1];
	end

	// ---------------------------------------------------------------
	// Stage 38: drop the power-of-two part, take magnitudes for /25
	// ---------------------------------------------------------------
	logic signed [57:0] pga_c, zga_c;
	logic signed [47:0] y1_c;
	logic signed [48:0] n1_c;
	logic signed [31:0] y2_c;
	logic signed [32:0] n2_c;
	logic [45:0]        u1_s38;
	logic [30:0]        u2_s38;
	logic               neg1_s38, neg2_s38;
	vbp_pkg::side_t     side_s38;

	assign pga_c = pg_s37 + 58'sd12800;
	assign zga_c = zg_s37 + 58'sd838860800;
	assign y1_c  = pga_c[57:10];
	assign y2_c  = zga_c[57:26];
	assign n1_c  = 49'sd24 - y1_c;
	assign n2_c  = 33'sd24 - y2_c;

	always_ff @(posedge clk) begin
		neg1_s38 <= y1_c[47];
		neg2_s38 <= y2_c[31];
		u1_s38   <= y1_c[47] ? n1_c[45:0] : y1_c[45:0];
		u2_s38   <= y2_c[31] ? n2_c[30:0] : y2_c[30:0];
		side_s38 <= side_s37;
	end

	// ---------------------------------------------------------------
	// Stage 39: reciprocal partial products
	// ---------------------------------------------------------------
	localparam logic [23:0] RW_HI = vbp_pkg::RECIP25_WIDE[46:23];
	localparam logic [22:0] RW_LO = vbp_pkg::RECIP25_WIDE[22:0];

	logic [46:0]    hh_s39, lh_s39;
	logic [45:0]    hl_s39, ll_s39;
	logic [62:0]    pp2_s39;
	logic           neg1_s39, neg2_s39;
	vbp_pkg::side_t side_s39;

	always_ff @(posedge clk) begin
		hh_s39   <= u1_s38[45:23] * RW_HI;
		hl_s39   <= u1_s38[45:23] * RW_LO;
		lh_s39   <= u1_s38[22:0] * RW_HI;
		ll_s39   <= u1_s38[22:0] * RW_LO;
		pp2_s39  <= u2_s38 * vbp_pkg::RECIP25_MID;
		neg1_s39 <= neg1_s38;
		neg2_s39 <= neg2_s38;
		side_s39 <= side_s38;
	end

	// ---------------------------------------------------------------
	// Stage 40: sum partials, restore signs
	// ---------------------------------------------------------------
	logic [93:0]        wide_c;
	logic signed [43:0] q1_c;
	logic signed [27:0] q2_c;
	logic signed [43:0] t_s40;
	logic signed [27:0] zzg_s40;
	vbp_pkg::side_t     side_s40;

	assign wide_c = ({47'b0, hh_s39} << 46)
		+ (({48'b0, hl_s39} + {47'b0, lh_s39}) << 23)
		+ {48'b0, ll_s39};
	assign q1_c = {1'b0, wide_c[93:51]};
	assign q2_c = {1'b0, pp2_s39[62:36]};

	always_ff @(posedge clk) begin
		t_s40    <= neg1_s39 ? -q1_c : q1_c;
		zzg_s40  <= neg2_s39 ? -q2_c : q2_c;
		side_s40 <= side_s39;
	end

	// ---------------------------------------------------------------
	// Stage 41: stretch products, screen y
	// ---------------------------------------------------------------
	logic signed [16:0] stretch_s;
	logic signed [22:0] th_c;
	logic [21:0]        r35a_c;
	logic signed [14:0] r35_c;
	logic signed [39:0] syw_c;
	logic signed [39:0] thsq_s41;
	logic [36:0]        tlsq_s41;
	logic [18:0]        sy_s41;
	vbp_pkg::side_t     side_s41;

	assign stretch_s = {1'b0, stretch_q};
	assign th_c      = t_s40[43:21];
	assign r35a_c    = zoom_q * 6'd35 + 22'd128;
	assign r35_c     = {1'b0, r35a_c[21:8]};
	assign syw_c     = ground_y_q - r35_c - zzg_s40;

	always_ff @(posedge clk) begin
		thsq_s41 <= th_c * stretch_s;
		tlsq_s41 <= t_s40[20:0] * stretch_q;
		sy_s41   <= vbp_pkg::sat19(syw_c);
		side_s41 <= side_s40;
	end

	// ---------------------------------------------------------------
	// Output registers: screen x, behind masking
	// ---------------------------------------------------------------
	logic signed [60:0] sxs_c;
	logic signed [32:0] sxr_c;
	logic signed [39:0] sxw_c;

	assign sxs_c = (thsq_s41 <<< 21) + $signed({1'b0, tlsq_s41}) + 61'sd134217728;
	assign sxr_c = sxs_c[60:28];
	assign sxw_c = centre_x_q + sxr_c;

	always_ff @(posedge clk) begin
		world_x    <= side_s41.wx;
		world_y    <= side_s41.wy;
		world_z    <= side_s41.wz;
		view_depth <= side_s41.vd;
		behind     <= side_s41.behind;
		screen_x   <= side_s41.behind ? 19'd0 : vbp_pkg::sat19(sxw_c);
		screen_y   <= side_s41.behind ? 19'd0 : sy_s41;
	end

endmodule

[test/testbench.sv]
// Self-checking testbench for the vertex blend and perspective projection block.
//
// The stimulus is built up front as a queue of pending operations. Each
// operation is one of three kinds: a vertex, a register write, or a pause that
// waits until every expected item has come back. A clocked driver pops that
// queue at the falling edge. A clocked monitor works at the rising edge: it
// tracks register writes, predicts each vertex as it is taken, and checks each
// item that leaves the block against the oldest prediction.
module testbench;

	typedef enum logic [1:0] {OP_VERTEX, OP_CFG, OP_DRAIN} op_kind_t;

	// register indexes past the last register
	localparam logic [vbp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [vbp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		op_kind_t                          kind;
		int                                idle_pct;
		logic signed [15:0]                fx, fy, fz, sx, sy, sz;
		logic [vbp_pkg::CFG_IDX_W-1:0]     idx;
		logic [vbp_pkg::CFG_DATA_W-1:0]    data;
	} op_t;

	typedef struct {
		logic signed [15:0] wx, wy, wz;
		logic signed [18:0] scr_x, scr_y;
		logic signed [15:0] depth;
		logic               behind;
	} proj_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [15:0] second_x = '0, second_y = '0, second_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [vbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic done;
	logic signed [15:0] world_x, world_y, world_z, view_depth;
	logic signed [18:0] screen_x, screen_y;
	logic behind;

	vertex_blend_project dut (.*);

	// mirror of the block's registers, updated as writes are taken
	longint      centre_q, ground_q;
	longint      zoom_q, stretch_q, blend_q;
	bit          facing_q;

	op_t         pending[$];
	proj_t       projections[$];
	int          errors = 0;
	int          vertices_taken = 0;
	int          cfg_taken = 0;
	int          behind_seen = 0;
	bit          took_vertex = 0;
	bit          took_cfg = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the handshake never completes
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	// nearest, ties toward plus infinity; d positive and even
	function automatic longint round_div(longint n, longint d);
		return floor_div(n + d / 2, d);
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// blend, turn, camera, perspective divide
	function automatic proj_t project_vertex(op_t v);
		proj_t  r;
		longint a[3], b[3], m[3];
		longint wx, wy, px, py, pz, zz, dd, den, num, g, t;
		a[0] = v.fx; a[1] = v.fy; a[2] = v.fz;
		b[0] = v.sx; b[1] = v.sy; b[2] = v.sz;
		for (int i = 0; i < 3; i++)
			m[i] = a[i] * 4096 + (b[i] - a[i]) * blend_q;
		if (facing_q) begin
			wx = m[1];
			wy = -m[0];
		end else begin
			wx = -m[1];
			wy = m[0];
		end
		px = round_div(wy * 53338 - wx * 38079, 65536);
		py = round_div(wy * 38079 + wx * 53338, 65536);
		pz = m[2] - longint'(3500) * 4096;
		zz = round_div(pz * 62609 - py * 19367, 65536);
		dd = round_div(pz * 19367 + py * 62609, 65536);
		den = 64'sd1509949440000 + dd * zoom_q;
		r.scr_x = '0;
		r.scr_y = '0;
		r.behind = 1'b0;
		if (den <= 0) begin
			r.behind = 1'b1;
		end else begin
			num = zoom_q * 368640000 * 65536;
			g = (num + den / 2) / den;
			if (g > 268435455)
				g = 268435455;
			t = round_div(px * g, 25600);
			r.scr_x = 19'(clamp(centre_q + round_div(t * stretch_q, 268435456), 19));
			r.scr_y = 19'(clamp(ground_q - round_div(35 * zoom_q, 256)
				- round_div(zz * g, 1677721600), 19));
		end
		r.wx = 16'(clamp(round_div(wx, 4096), 16));
		r.wy = 16'(clamp(round_div(wy, 4096), 16));
		r.wz = 16'(clamp(round_div(m[2], 4096), 16));
		r.depth = 16'(clamp(round_div(dd, 1600), 16));
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	task automatic add_vertex(int idle, int fx, int fy, int fz, int sx, int sy, int sz);
		op_t o;
		o.kind = OP_VERTEX;
		o.idle_pct = idle;
		o.fx = 16'(fx); o.fy = 16'(fy); o.fz = 16'(fz);
		o.sx = 16'(sx); o.sy = 16'(sy); o.sz = 16'(sz);
		pending.push_back(o);
	endtask

	task automatic add_cfg(logic [vbp_pkg::CFG_IDX_W-1:0] idx,
		logic [vbp_pkg::CFG_DATA_W-1:0] data);
		op_t o;
		o.kind = OP_CFG;
		o.idle_pct = 0;
		o.idx = idx;
		o.data = data;
		pending.push_back(o);
	endtask

	task automatic add_drain();
		op_t o;
		o.kind = OP_DRAIN;
		o.idle_pct = 0;
		pending.push_back(o);
	endtask

	// wait for every prediction to be matched, then write all registers
	task automatic add_settings(int cx, int gy, int zm, int st, int bl, int fc);
		add_drain();
		add_cfg(vbp_pkg::REG_CENTRE_X, 19'(cx));
		add_cfg(vbp_pkg::REG_GROUND_Y, 19'(gy));
		add_cfg(vbp_pkg::REG_ZOOM, 19'(zm));
		add_cfg(vbp_pkg::REG_STRETCH, 19'(st));
		add_cfg(vbp_pkg::REG_BLEND, 19'(bl));
		add_cfg(vbp_pkg::REG_FACING, 19'(fc));
	endtask

	function automatic int pick_coord(int mode);
		int corners[4] = '{-32768, 32767, 0, -1};
		case (mode)
			0: return $urandom_range(0, 12000) - 6000;
			1: return $signed(16'($urandom));
			default: return corners[$urandom_range(0, 3)];
		endcase
	endfunction

	task automatic add_random_vertices(int count, int idle);
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 9);
			mode = mode < 6 ? 0 : (mode < 9 ? 1 : 2);
			add_vertex(idle, pick_coord(mode), pick_coord(mode), pick_coord(mode),
				pick_coord(mode), pick_coord(mode), pick_coord(mode));
		end
	endtask

	// driver: hold each operation until the block takes it, change at the falling edge
	op_t cur;
	bit  active = 0;
	int  settle = 0;

	always @(negedge clk) begin
		bit s, v;
		s = 0;
		v = 0;
		if (arst_n) begin
			if (active && ((cur.kind == OP_VERTEX && took_vertex) ||
					(cur.kind == OP_CFG && took_cfg)))
				active = 0;
			if (!active && pending.size() > 0 &&
					$urandom_range(0, 99) >= pending[0].idle_pct) begin
				cur = pending.pop_front();
				active = 1;
				settle = 0;
			end
			if (active) begin
				case (cur.kind)
					OP_VERTEX: begin
						s = 1;
						first_x <= cur.fx;
						first_y <= cur.fy;
						first_z <= cur.fz;
						second_x <= cur.sx;
						second_y <= cur.sy;
						second_z <= cur.sz;
					end
					OP_CFG: begin
						v = 1;
						cfg_index <= cur.idx;
						cfg_data <= cur.data;
					end
					default: begin
						// pause: count quiet cycles with nothing in flight before moving on
						if (projections.size() == 0)
							settle++;
						if (settle >= 50)
							active = 0;
					end
				endcase
			end
		end
		start <= s;
		cfg_valid <= v;
	end

	// monitor: track writes, predict taken vertices, check outgoing items
	always @(posedge clk) begin
		proj_t e;
		op_t   in_v;
		took_vertex = 0;
		took_cfg = 0;
		if (arst_n) begin
			if (done) begin
				if (projections.size() == 0) begin
					report_mismatch("unexpected item, world_x", world_x, 0);
				end else begin
					e = projections.pop_front();
					if (world_x !== e.wx) report_mismatch("world_x", world_x, e.wx);
					if (world_y !== e.wy) report_mismatch("world_y", world_y, e.wy);
					if (world_z !== e.wz) report_mismatch("world_z", world_z, e.wz);
					if (screen_x !== e.scr_x) report_mismatch("screen_x", screen_x, e.scr_x);
					if (screen_y !== e.scr_y) report_mismatch("screen_y", screen_y, e.scr_y);
					if (view_depth !== e.depth)
						report_mismatch("view_depth", view_depth, e.depth);
					if (behind !== e.behind) report_mismatch("behind", behind, e.behind);
				end
			end
			if (start && !busy) begin
				in_v.fx = first_x; in_v.fy = first_y; in_v.fz = first_z;
				in_v.sx = second_x; in_v.sy = second_y; in_v.sz = second_z;
				e = project_vertex(in_v);
				if (e.behind)
					behind_seen++;
				projections.push_back(e);
				vertices_taken++;
				took_vertex = 1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					vbp_pkg::REG_CENTRE_X: centre_q = longint'($signed(cfg_data));
					vbp_pkg::REG_GROUND_Y: ground_q = longint'($signed(cfg_data));
					vbp_pkg::REG_ZOOM:     zoom_q = cfg_data[15:0];
					vbp_pkg::REG_STRETCH:  stretch_q = cfg_data[15:0];
					vbp_pkg::REG_BLEND:    blend_q = cfg_data[11:0];
					vbp_pkg::REG_FACING:   facing_q = cfg_data[0];
					default: ;
				endcase
				cfg_taken++;
				took_cfg = 1;
			end
		end
	end

	initial begin
		int idle;
		centre_q = 0;
		ground_q = 0;
		zoom_q = 4096;
		stretch_q = 4096;
		blend_q = 0;
		facing_q = 0;

		// directed: reset settings, then the extremes of every register
		add_vertex(0, 0, 0, 0, 0, 0, 0);
		add_vertex(0, 32767, 32767, 32767, 32767, 32767, 32767);
		add_vertex(0, -32768, -32768, -32768, -32768, -32768, -32768);
		add_vertex(0, 32767, -32768, 32767, -32768, 32767, -32768);
		add_vertex(0, 1000, -2000, 3500, 1200, -1800, 3600);
		// largest zoom and far-back depth to push the view behind the camera
		add_settings(-262144, 262143, 65535, 65535, 4095, 1);
		add_vertex(0, 0, 0, 0, 0, 0, 0);
		add_vertex(0, -32768, -32768, -32768, -32768, -32768, -32768);
		add_vertex(0, 32767, 32767, -32768, 32767, 32767, -32768);
		add_vertex(0, -32768, 32767, -32768, -32768, 32767, -32768);
		add_vertex(0, 32767, -32768, 32767, 32767, -32768, 32767);
		add_vertex(0, -32768, -32768, 32767, 32767, 32767, -32768);
		add_vertex(0, 500, 500, 500, -500, -500, -500);
		add_settings(262143, -262144, 0, 0, 0, 0);
		add_vertex(0, 32767, 32767, 32767, -32768, -32768, -32768);
		add_vertex(0, -32768, 32767, 0, 32767, -32768, 0);
		add_vertex(0, 0, 0, 0, 0, 0, 0);
		// indexes past the last register are dropped
		add_drain();
		add_cfg(REG_SPARE_A, 19'h7ffff);
		add_cfg(REG_SPARE_B, 19'h12345);
		add_settings(160, -4000, 1, 4096, 2048, 1);
		add_vertex(0, 32767, 0, -32768, -32768, 0, 32767);
		add_vertex(0, -1, -1, -1, 1, 1, 1);
		add_vertex(0, 123, -456, 789, -321, 654, -987);

		// random phases: sender idles 23%, then 58%, then never
		for (int p = 0; p < 9; p++) begin
			idle = p < 3 ? 23 : (p < 6 ? 58 : 0);
			case (p % 3)
				0: add_settings($urandom_range(0, 8000) - 4000, $urandom_range(0, 12000),
					$urandom_range(2000, 20000), $urandom_range(2000, 8000),
					$urandom_range(0, 4095), $urandom_range(0, 1));
				1: add_settings($urandom, $urandom, $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 1));
				default: add_settings($urandom, $urandom, $urandom_range(40000, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 1));
			endcase
			add_random_vertices(215, idle);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// hold until the queue empties, then let the pipeline drain
		wait (pending.size() == 0 && !active);
		wait (projections.size() == 0);
		repeat (60) @(posedge clk);

		$display("covered %0d vertices (%0d behind the camera) and %0d register writes",
			vertices_taken, behind_seen, cfg_taken);
		$display("across reset, extreme and random settings with both facings");
		if (errors == 0 && projections.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
